@@ rtl/core/irpt_pkg.sv @@
package irpt_pkg;

   localparam int RING_DEPTH = 64;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);

   localparam int WORD_W   = 16;
   localparam int LENGTH_W = 15;
   localparam int BURST_BIT = 15;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_CLOCK  = 4'd1;

   localparam logic [7:0] HALF_PERIOD_RESET = 8'd157;
   localparam logic [7:0] COUNTER_RESET     = 8'hFF;

   localparam logic [1:0] CMD_PUSH    = 2'd0;
   localparam logic [1:0] CMD_FRAME   = 2'd1;
   localparam logic [1:0] CMD_CARRIER = 2'd2;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [WORD_W-1:0] entry_word;
   } req_type;

   typedef struct packed {
      logic ir_out;
      logic transmitting;
      logic ring_full;
      logic push_dropped;
   } rsp_type;

   typedef struct packed {
      logic step;
      logic stop;
      logic start;
   } carrier_ctrl_type;

endpackage

@@ rtl/core/irpt_ram.sv @@
module irpt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/irpt_ring.sv @@
module irpt_ring
   import irpt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [WORD_W-1:0] wr_word,
   input  logic              pop,
   output logic [WORD_W-1:0] head_word,
   output logic              full,
   output logic              empty,
   output logic              full_next
);

   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              byp_sel_ff, byp_sel_in;
   logic [WORD_W-1:0] byp_word_ff;
   logic [WORD_W-1:0] ram_rdata;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
   end

   // a write landing on the entry being fetched goes around the ram
   assign byp_sel_in = wr_en && (wr_ptr_ff == rd_ptr_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff  <= '0;
         wr_ptr_ff  <= '0;
         count_ff   <= '0;
         byp_sel_ff <= 1'b0;
      end else begin
         rd_ptr_ff  <= rd_ptr_in;
         wr_ptr_ff  <= wr_ptr_in;
         count_ff   <= count_in;
         byp_sel_ff <= byp_sel_in;
      end
      if (wr_en) begin
         byp_word_ff <= wr_word;
      end
   end

   irpt_ram #(
      .WIDTH(WORD_W),
      .DEPTH(RING_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (wr_word),
      .rd_addr (rd_ptr_in),
      .rd_data (ram_rdata)
   );

   assign head_word = byp_sel_ff ? byp_word_ff : ram_rdata;
   assign full      = (count_ff == CNT_FULL);
   assign empty     = (count_ff == '0);
   assign full_next = (count_in == CNT_FULL);

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_FULL)
      else $error("ring count above depth");
   assert property (@(posedge clock) disable iff (reset) !(wr_en && full))
      else $error("write into full ring");
   assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("ring pointers disagree with count");
`endif

endmodule

@@ rtl/core/irpt_carrier.sv @@
module irpt_carrier
   import irpt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  carrier_ctrl_type ctrl,
   input  logic             fast_clock,
   input  logic [7:0]       half_period,
   output logic             running,
   output logic             level_next
);

   logic       running_ff, running_in;
   logic       level_ff, level_in;
   logic [1:0] prescale_ff, prescale_in;
   logic [7:0] counter_ff, counter_in;
   logic [7:0] compare_ff, compare_in;
   logic [7:0] counter_inc;

   assign counter_inc = counter_ff + 8'd1;

   always_comb begin
      running_in  = running_ff;
      level_in    = level_ff;
      prescale_in = prescale_ff;
      counter_in  = counter_ff;
      compare_in  = compare_ff;
      if (ctrl.stop) begin
         running_in  = ctrl.start;
         level_in    = 1'b0;
         prescale_in = '0;
         counter_in  = COUNTER_RESET;
      end else if (ctrl.step && running_ff) begin
         prescale_in = fast_clock ? prescale_ff : prescale_ff + 2'd1;
         if (fast_clock || (prescale_in == 2'd0)) begin
            counter_in = counter_inc;
            if (counter_inc == compare_ff) begin
               level_in   = !level_ff;
               compare_in = compare_ff + half_period;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         level_ff    <= 1'b0;
         prescale_ff <= '0;
         counter_ff  <= COUNTER_RESET;
         compare_ff  <= '0;
      end else begin
         running_ff  <= running_in;
         level_ff    <= level_in;
         prescale_ff <= prescale_in;
         counter_ff  <= counter_in;
         compare_ff  <= compare_in;
      end
   end

   assign running    = running_ff;
   assign level_next = level_in;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      !running_ff |-> (!level_ff && prescale_ff == 2'd0 && counter_ff == COUNTER_RESET))
      else $error("stopped carrier not parked");
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.step && !ctrl.stop && !running_ff) |=> $stable(compare_ff))
      else $error("compare moved while carrier stopped");
`endif

endmodule

@@ rtl/core/irpt_outbuf.sv @@
module irpt_outbuf
   import irpt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    in_ready,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_ready
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    load, take;

   assign in_ready = !skid_valid_ff;
   assign load     = in_valid && in_ready;
   assign take     = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = in_data;
            main_valid_in = load;
         end
      end else if (load) begin
         if (main_valid_ff) begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end else begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> main_valid_ff)
      else $error("skid holds a beat ahead of main");
`endif

endmodule

@@ rtl/core/ir_pulse_train_transmitter.sv @@
// a result beat is loaded into the output buffer (main, or skid if main is held)
// one request beat per cycle while skid is empty; each is one state-update pass
// a two-beat output buffer takes one further request while responses stall
// reset (synchronous, active high) clears pointers, counters, carrier and csrs;
// ring contents are not cleared, no clearing pass, ready right after reset
module ir_pulse_train_transmitter
   import irpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [7:0]          half_period_ff;
   logic                fast_clock_ff;
   logic                tx_active_ff, tx_active_in;
   logic [LENGTH_W-1:0] remaining_ff, remaining_in;

   logic              accept;
   logic              is_push, is_frame, is_carrier;
   logic              ring_wr, ring_pop, dropped;
   logic [WORD_W-1:0] head_word;
   logic              ring_full, ring_empty, ring_full_next;
   logic              entry_done;
   carrier_ctrl_type  carrier_ctrl;
   logic              carrier_running, level_next;
   rsp_type           result;

   assign csr_ready = 1'b1;

   assign accept     = req_valid && req_ready;
   assign is_push    = accept && (req_data.cmd == CMD_PUSH);
   assign is_frame   = accept && (req_data.cmd == CMD_FRAME);
   assign is_carrier = accept && (req_data.cmd == CMD_CARRIER);

   assign dropped    = is_push && ring_full;
   assign ring_wr    = is_push && !ring_full;
   // current entry has run out on this frame tick
   assign entry_done = is_frame && tx_active_ff && (remaining_ff == '0);
   assign ring_pop   = entry_done && !ring_empty;

   assign carrier_ctrl.step  = is_carrier;
   assign carrier_ctrl.stop  = entry_done;
   assign carrier_ctrl.start = ring_pop && head_word[BURST_BIT];

   always_comb begin
      tx_active_in = tx_active_ff;
      remaining_in = remaining_ff;
      if (ring_wr && !tx_active_ff) begin
         tx_active_in = 1'b1;
         remaining_in = '0;
      end
      if (is_frame && tx_active_ff) begin
         if (remaining_ff != '0) begin
            remaining_in = remaining_ff - 1'b1;
         end else if (ring_empty) begin
            tx_active_in = 1'b0;
         end else begin
            remaining_in = head_word[LENGTH_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         fast_clock_ff  <= 1'b0;
         tx_active_ff   <= 1'b0;
         remaining_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HALF_PERIOD: half_period_ff <= csr_wdata[7:0];
               CSR_FAST_CLOCK:  fast_clock_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
         tx_active_ff <= tx_active_in;
         remaining_ff <= remaining_in;
      end
   end

   irpt_ring u_ring (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (ring_wr),
      .wr_word   (req_data.entry_word),
      .pop       (ring_pop),
      .head_word (head_word),
      .full      (ring_full),
      .empty     (ring_empty),
      .full_next (ring_full_next)
   );

   irpt_carrier u_carrier (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (carrier_ctrl),
      .fast_clock  (fast_clock_ff),
      .half_period (half_period_ff),
      .running     (carrier_running),
      .level_next  (level_next)
   );

   assign result.ir_out       = level_next;
   assign result.transmitting = tx_active_in;
   assign result.ring_full    = ring_full_next;
   assign result.push_dropped = dropped;

   irpt_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (result),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_ready (rsp_ready)
   );

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset) carrier_running |-> tx_active_ff)
      else $error("carrier running while not transmitting");
   assert property (@(posedge clock) disable iff (reset) (remaining_ff != '0) |-> tx_active_ff)
      else $error("ticks remaining while not transmitting");
   assert property (@(posedge clock) disable iff (reset) !tx_active_ff |-> ring_empty)
      else $error("ring holds entries while idle");
`endif

endmodule
